/* hw/rtl/srt_pkg.sv */
// Shared constants, status codes and types of the shortest-remaining-time scheduler.
`default_nettype none

package srt_pkg;

   // Sizing
   localparam int MAX_JOBS = 16;
   localparam int IDX_W    = $clog2(MAX_JOBS);
   localparam int SLOT_W   = 4;
   localparam int SVC_W    = 16;
   localparam int TIME_W   = 32;
   localparam int STAT_W   = 3;

   // Request actions
   localparam logic ACT_ARRIVE = 1'b0;
   localparam logic ACT_TICK   = 1'b1;

   // Result status codes
   localparam logic [STAT_W-1:0] ST_ACCEPT = 3'd0;
   localparam logic [STAT_W-1:0] ST_RAN    = 3'd1;
   localparam logic [STAT_W-1:0] ST_IDLE   = 3'd2;
   localparam logic [STAT_W-1:0] ST_BUSY   = 3'd3;
   localparam logic [STAT_W-1:0] ST_ZERO   = 3'd4;

   typedef logic [IDX_W-1:0] idx_type;

   // Control from the sequencer into the minimum finder
   typedef struct packed {
      logic    clear;
      logic    valid;
      idx_type idx;
   } pick_ctl_type;

   // Running result of the minimum finder
   typedef struct packed {
      logic             found;
      idx_type          slot;
      logic [SVC_W-1:0] best;
   } pick_res_type;

endpackage

`default_nettype wire

/* hw/rtl/srt_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module srt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/srt_pick.sv */
// Running minimum finder: keeps the busy slot with least remaining time seen so far.
`default_nettype none

module srt_pick (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire srt_pkg::pick_ctl_type          ctl,
   input  wire logic [srt_pkg::MAX_JOBS-1:0]   busy_slots,
   input  wire logic [srt_pkg::SVC_W-1:0]      rd_data,
   output srt_pkg::pick_res_type               res
);

   import srt_pkg::*;

   logic             found_ff, found_in;
   idx_type          slot_ff, slot_in;
   logic [SVC_W-1:0] best_ff, best_in;
   logic             take;

   // Strictly less keeps the lower slot on a tie, as slots arrive in order
   assign take = ctl.valid && busy_slots[ctl.idx] && (!found_ff || (rd_data < best_ff));

   always_comb begin
      found_in = found_ff;
      slot_in  = slot_ff;
      best_in  = best_ff;
      priority if (ctl.clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in = 1'b1;
         slot_in  = ctl.idx;
         best_in  = rd_data;
      end else begin
         // nothing new: hold the best so far
         found_in = found_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      slot_ff <= slot_in;
      best_ff <= best_in;
   end

   assign res.found = found_ff;
   assign res.slot  = slot_ff;
   assign res.best  = best_ff;

endmodule

`default_nettype wire

/* hw/rtl/shortest_remaining_time_scheduler_core.sv */
// Top level of the shortest-remaining-time scheduler: sequencer, minimum finder, memories and result register.
//
// A request is taken when start is high and busy is low; every request gives exactly one
// result, shown for one cycle with rsp_strobe, and the receiver cannot stall it. An arrival
// is settled in the accepting cycle: its result appears on the next cycle and busy never
// rises, so a new request may follow at once. A tick scans the remaining-time memory one
// slot per cycle through its single read port, then reads the chosen job's arrival stamp
// and writes back its remaining time, which is skipped when no job waits; busy stays high
// meanwhile, and the result shows in the cycle busy falls, when the next request may
// already be taken. Remaining time and arrival stamp live in RAMs that hold no reset value;
// besides the control state, only slot occupancy and the time counter are cleared by reset,
// so no clearing pass is needed.
`default_nettype none

module shortest_remaining_time_scheduler_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_action,
   input  wire logic [srt_pkg::SLOT_W-1:0]    req_job_slot,
   input  wire logic [srt_pkg::SVC_W-1:0]     req_service_time,
   output logic                               rsp_strobe,
   output logic      [srt_pkg::STAT_W-1:0]    rsp_status,
   output logic      [srt_pkg::SLOT_W-1:0]    rsp_ran_slot,
   output logic      [srt_pkg::SVC_W-1:0]     rsp_remaining_after,
   output logic                               rsp_finished,
   output logic      [srt_pkg::TIME_W-1:0]    rsp_finish_stamp,
   output logic      [srt_pkg::TIME_W-1:0]    rsp_turnaround
);

   import srt_pkg::*;

   localparam idx_type LAST_IDX = IDX_W'(MAX_JOBS - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_ARD,
      S_FIN
   } state_type;

   state_type             state_ff, state_in;
   idx_type               scan_ff, scan_in;
   logic                  chk_valid_ff, chk_valid_in;
   idx_type               chk_idx_ff, chk_idx_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic [MAX_JOBS-1:0]   busy_slots_ff, busy_slots_in;

   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [STAT_W-1:0]     status_ff, status_in;
   logic [SLOT_W-1:0]     ran_slot_ff, ran_slot_in;
   logic [SVC_W-1:0]      remaining_ff, remaining_in;
   logic                  finished_ff, finished_in;
   logic [TIME_W-1:0]     finish_stamp_ff, finish_stamp_in;
   logic [TIME_W-1:0]     turnaround_ff, turnaround_in;

   logic                  accept;
   idx_type               arr_idx;
   logic                  slot_out_of_range;
   logic                  rem_we, arr_we;
   idx_type               rem_wr_addr;
   logic [SVC_W-1:0]      rem_wr_data;
   logic [SVC_W-1:0]      rem_rd_data;
   logic [TIME_W-1:0]     arr_rd_data;
   logic [SVC_W-1:0]      rem_dec;
   logic [TIME_W-1:0]     now_inc;
   pick_ctl_type          pick_ctl;
   pick_res_type          pick_res;

   assign accept            = start && (state_ff == S_IDLE);
   assign arr_idx           = IDX_W'(req_job_slot);
   assign slot_out_of_range = ({{(TIME_W-SLOT_W){1'b0}}, req_job_slot} >= TIME_W'(MAX_JOBS));
   assign rem_dec           = pick_res.best - SVC_W'(1);
   assign now_inc           = now_ff + TIME_W'(1);

   // Minimum finder fed by the scan read stream
   assign pick_ctl.clear = accept;
   assign pick_ctl.valid = chk_valid_ff;
   assign pick_ctl.idx   = chk_idx_ff;

   srt_pick u_pick (
      .clock      (clock),
      .reset      (reset),
      .ctl        (pick_ctl),
      .busy_slots (busy_slots_ff),
      .rd_data    (rem_rd_data),
      .res        (pick_res)
   );

   // Remaining time per slot; read address walks the slots during a scan
   srt_ram #(.WIDTH(SVC_W), .DEPTH(MAX_JOBS)) u_rem_ram (
      .clock   (clock),
      .wr_en   (rem_we),
      .wr_addr (rem_wr_addr),
      .wr_data (rem_wr_data),
      .rd_addr (scan_ff),
      .rd_data (rem_rd_data)
   );

   // Arrival stamp per slot; read at the chosen slot once the scan is over
   srt_ram #(.WIDTH(TIME_W), .DEPTH(MAX_JOBS)) u_arr_ram (
      .clock   (clock),
      .wr_en   (arr_we),
      .wr_addr (arr_idx),
      .wr_data (now_ff),
      .rd_addr (pick_res.slot),
      .rd_data (arr_rd_data)
   );

   // Sequencer: next state, memory writes and the result
   always_comb begin
      state_in        = state_ff;
      scan_in         = scan_ff;
      chk_valid_in    = 1'b0;
      chk_idx_in      = scan_ff;
      now_in          = now_ff;
      busy_slots_in   = busy_slots_ff;
      rsp_strobe_in   = 1'b0;
      status_in       = ST_IDLE;
      ran_slot_in     = '0;
      remaining_in    = '0;
      finished_in     = 1'b0;
      finish_stamp_in = '0;
      turnaround_in   = '0;
      rem_we          = 1'b0;
      arr_we          = 1'b0;
      rem_wr_addr     = arr_idx;
      rem_wr_data     = req_service_time;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_action == ACT_TICK) begin
                  state_in = S_SCAN;
                  scan_in  = '0;
               end else begin
                  rsp_strobe_in = 1'b1;
                  priority if (req_service_time == '0) begin
                     status_in = ST_ZERO;
                  end else if (slot_out_of_range || busy_slots_ff[arr_idx]) begin
                     status_in = ST_BUSY;
                  end else begin
                     status_in              = ST_ACCEPT;
                     rem_we                 = 1'b1;
                     arr_we                 = 1'b1;
                     busy_slots_in[arr_idx] = 1'b1;
                  end
               end
            end
         end
         S_SCAN: begin
            chk_valid_in = 1'b1;
            chk_idx_in   = scan_ff;
            if (scan_ff == LAST_IDX) begin
               state_in = S_DRAIN;
            end else begin
               scan_in = scan_ff + IDX_W'(1);
            end
         end
         S_DRAIN: begin
            // last compare lands in the finder at the end of this cycle
            state_in = S_ARD;
         end
         S_ARD: begin
            if (pick_res.found) begin
               state_in = S_FIN;
            end else begin
               state_in      = S_IDLE;
               now_in        = now_inc;
               rsp_strobe_in = 1'b1;
               status_in     = ST_IDLE;
            end
         end
         S_FIN: begin
            state_in      = S_IDLE;
            now_in        = now_inc;
            rem_we        = 1'b1;
            rem_wr_addr   = pick_res.slot;
            rem_wr_data   = rem_dec;
            rsp_strobe_in = 1'b1;
            status_in     = ST_RAN;
            ran_slot_in   = SLOT_W'(pick_res.slot);
            remaining_in  = rem_dec;
            if (rem_dec == '0) begin
               busy_slots_in[pick_res.slot] = 1'b0;
               finished_in     = 1'b1;
               finish_stamp_in = now_inc;
               turnaround_in   = now_inc - arr_rd_data;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, control and registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         chk_valid_ff  <= 1'b0;
         now_ff        <= '0;
         busy_slots_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         chk_valid_ff  <= chk_valid_in;
         now_ff        <= now_in;
         busy_slots_ff <= busy_slots_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      scan_ff         <= scan_in;
      chk_idx_ff      <= chk_idx_in;
      status_ff       <= status_in;
      ran_slot_ff     <= ran_slot_in;
      remaining_ff    <= remaining_in;
      finished_ff     <= finished_in;
      finish_stamp_ff <= finish_stamp_in;
      turnaround_ff   <= turnaround_in;
   end

   assign busy                = (state_ff != S_IDLE);
   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_status          = status_ff;
   assign rsp_ran_slot        = ran_slot_ff;
   assign rsp_remaining_after = remaining_ff;
   assign rsp_finished        = finished_ff;
   assign rsp_finish_stamp    = finish_stamp_ff;
   assign rsp_turnaround      = turnaround_ff;

endmodule

`default_nettype wire

/* hw/rtl/srt_chk.sv */
// Port-level checker for the scheduler core, bound to the top level.
`default_nettype none

module srt_chk (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic                          busy,
   input  wire logic                          rsp_strobe,
   input  wire logic [srt_pkg::STAT_W-1:0]    rsp_status,
   input  wire logic [srt_pkg::SLOT_W-1:0]    rsp_ran_slot,
   input  wire logic [srt_pkg::SVC_W-1:0]     rsp_remaining_after,
   input  wire logic                          rsp_finished
);

   import srt_pkg::*;

   // Every accepted request either completes next cycle or holds the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_strobe || busy))
      else $error("request neither answered nor in progress");

   // A result is only shown once the block is free again
   a_result_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while busy");

   // Busy only rises on a taken request
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a request");

   // A finished job ran and has nothing left
   a_finish_ran: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_finished) |-> ((rsp_status == ST_RAN) && (rsp_remaining_after == '0)))
      else $error("finish reported without a completed run");

   // Results other than a run carry no slot or remaining time
   a_other_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != ST_RAN)) |->
         ((rsp_ran_slot == '0) && (rsp_remaining_after == '0) && !rsp_finished))
      else $error("non-run result carries run fields");

endmodule

bind shortest_remaining_time_scheduler_core srt_chk u_srt_chk (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .rsp_strobe          (rsp_strobe),
   .rsp_status          (rsp_status),
   .rsp_ran_slot        (rsp_ran_slot),
   .rsp_remaining_after (rsp_remaining_after),
   .rsp_finished        (rsp_finished)
);

`default_nettype wire
